/* rtl/core/ucd_pkg.sv */
package ucd_pkg;

  localparam int DEDUP_DEPTH_DEF = 256;
  localparam int HASH_W          = 32;
  localparam int CNT_W           = 32;
  localparam int ACT_W           = 2;
  localparam int ST_W            = 2;

  // command queue between front and back, power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // config port
  localparam int                 PADDR_W        = 3;
  localparam logic               REG_THRESHOLD  = 1'b0;
  localparam logic [CNT_W-1:0]   THRESHOLD_RST  = 32'd1000;

  typedef enum logic [ACT_W-1:0] {
    ACT_RISE  = 2'd0,
    ACT_DONE  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_BAD   = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_APPLIED = 2'd0,
    ST_DUP     = 2'd1,
    ST_ERROR   = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [HASH_W-1:0] hash;
    logic              store_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } bstate_t;

endpackage

/* rtl/core/ucd_ram.sv */
module ucd_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ucd_front.sv */
module ucd_front
  import ucd_pkg::*;
(
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [HASH_W-1:0] in_command_hash,
  input  logic              in_store_ok,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic missing_id;

  assign in_ready   = !q_full;
  assign q_push     = in_valid && !q_full;
  assign missing_id = (in_command_hash == '0);

  // done/reset without an id and unknown codes collapse to one error class
  always_comb begin
    q_cmd.hash     = in_command_hash;
    q_cmd.store_ok = in_store_ok;
    case (in_action)
      ACT_RISE:  q_cmd.action = ACT_RISE;
      ACT_DONE:  q_cmd.action = missing_id ? ACT_BAD : ACT_DONE;
      ACT_RESET: q_cmd.action = missing_id ? ACT_BAD : ACT_RESET;
      default:   q_cmd.action = ACT_BAD;
    endcase
  end

endmodule

/* rtl/core/ucd_fifo.sv */
module ucd_fifo
  import ucd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t             buf_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/ucd_back.sv */
module ucd_back
  import ucd_pkg::*;
#(
  parameter int DEDUP_DEPTH = DEDUP_DEPTH_DEF,
  localparam int AW = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1,
  localparam int CW = $clog2(DEDUP_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  threshold,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [CNT_W-1:0]  out_total_rises,
  output logic [CNT_W-1:0]  out_rises_since_service,
  output logic [CNT_W-1:0]  out_service_count,
  output logic [CNT_W-1:0]  out_total_at_last_service,
  output logic              out_service_due,
  output logic [CNT_W-1:0]  out_reset_epoch
);

  localparam int EW = ACT_W + HASH_W;

  bstate_t           state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              hit_r, hit_nxt;
  logic [CW-1:0]     seen_cnt_r, seen_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  since_r, since_nxt;
  logic [CNT_W-1:0]  svc_cnt_r, svc_cnt_nxt;
  logic [CNT_W-1:0]  last_total_r, last_total_nxt;
  logic              due_r, due_nxt;
  logic [CNT_W-1:0]  epoch_r, epoch_nxt;

  logic              mem_we;
  logic [EW-1:0]     mem_rdata;
  logic [EW-1:0]     entry;
  logic [CNT_W-1:0]  since_inc;
  logic              match;

  assign entry     = {cmd_r.action, cmd_r.hash};
  assign match     = rd_vld_r && (mem_rdata == entry);
  assign since_inc = since_r + 1'b1;

  ucd_ram #(
    .WIDTH (EW),
    .DEPTH (DEDUP_DEPTH)
  ) u_seen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (seen_cnt_r[AW-1:0]),
    .wdata (entry),
    .raddr (issue_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = rd_vld_r;
    hit_nxt        = hit_r;
    seen_cnt_nxt   = seen_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    total_nxt      = total_r;
    since_nxt      = since_r;
    svc_cnt_nxt    = svc_cnt_r;
    last_total_nxt = last_total_r;
    due_nxt        = due_r;
    epoch_nxt      = epoch_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          issue_nxt  = '0;
          rd_vld_nxt = 1'b0;
          hit_nxt    = 1'b0;
          if (q_cmd.action == ACT_DONE || q_cmd.action == ACT_RESET) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end

      // one read issued per cycle; data compared the cycle after
      S_SCAN: begin
        if (match) begin
          hit_nxt   = 1'b1;
          state_nxt = S_APPLY;
        end else if (issue_r < seen_cnt_r) begin
          issue_nxt  = issue_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_APPLY;
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end

      S_APPLY: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (cmd_r.action)
            ACT_RISE: begin
              if (cmd_r.store_ok) begin
                status_nxt = ST_APPLIED;
                total_nxt  = total_r + 1'b1;
                since_nxt  = since_inc;
                if (since_inc >= threshold) begin
                  due_nxt = 1'b1;
                end
              end else begin
                status_nxt = ST_ERROR;
              end
            end
            ACT_DONE, ACT_RESET: begin
              if (hit_r) begin
                status_nxt = ST_DUP;
              end else if (!cmd_r.store_ok) begin
                status_nxt = ST_ERROR;
              end else begin
                status_nxt = ST_APPLIED;
                since_nxt  = '0;
                due_nxt    = 1'b0;
                if (cmd_r.action == ACT_DONE) begin
                  svc_cnt_nxt    = svc_cnt_r + 1'b1;
                  last_total_nxt = total_r;
                end else begin
                  total_nxt      = '0;
                  svc_cnt_nxt    = '0;
                  last_total_nxt = '0;
                  epoch_nxt      = epoch_r + 1'b1;
                end
                // full table: applied but not remembered
                if (seen_cnt_r < CW'(DEDUP_DEPTH)) begin
                  mem_we       = 1'b1;
                  seen_cnt_nxt = seen_cnt_r + 1'b1;
                end
              end
            end
            default: status_nxt = ST_ERROR;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      issue_r      <= '0;
      seen_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_APPLIED;
      total_r      <= '0;
      since_r      <= '0;
      svc_cnt_r    <= '0;
      last_total_r <= '0;
      due_r        <= 1'b0;
      epoch_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_r        <= hit_nxt;
      issue_r      <= issue_nxt;
      seen_cnt_r   <= seen_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      status_r     <= status_nxt;
      total_r      <= total_nxt;
      since_r      <= since_nxt;
      svc_cnt_r    <= svc_cnt_nxt;
      last_total_r <= last_total_nxt;
      due_r        <= due_nxt;
      epoch_r      <= epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign out_valid                 = out_valid_r;
  assign out_status                = status_r;
  assign out_total_rises           = total_r;
  assign out_rises_since_service   = since_r;
  assign out_service_count         = svc_cnt_r;
  assign out_total_at_last_service = last_total_r;
  assign out_service_due           = due_r;
  assign out_reset_epoch           = epoch_r;

endmodule

/* rtl/core/usage_counter_with_command_dedup.sv */
// Flow: an accepted item passes the queue, is popped in S_IDLE and applied in S_APPLY, which
// waits while a shown result is not taken; a done or reset item first passes S_SCAN, where
// the dedup RAM is scanned one entry per cycle up to the fill count or an early hit. Only one
// item at a time is in the back end; a 2-entry queue takes items meanwhile.
// Reset (rst_n, synchronous): counters, fill count and queue clear, threshold goes to 1000;
// the dedup RAM is not cleared, only its first fill-count entries are ever compared.
module usage_counter_with_command_dedup
  import ucd_pkg::*;
#(
  parameter int DEDUP_DEPTH = DEDUP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [HASH_W-1:0]  in_command_hash,
  input  logic               in_store_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    out_status,
  output logic [CNT_W-1:0]   out_total_rises,
  output logic [CNT_W-1:0]   out_rises_since_service,
  output logic [CNT_W-1:0]   out_service_count,
  output logic [CNT_W-1:0]   out_total_at_last_service,
  output logic               out_service_due,
  output logic [CNT_W-1:0]   out_reset_epoch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0] threshold_r;
  logic             cfg_wr;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_THRESHOLD);
  assign prdata = (paddr[PADDR_W-1:2] == REG_THRESHOLD) ? threshold_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      threshold_r <= pwdata;
    end
  end

  ucd_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_command_hash (in_command_hash),
    .in_store_ok     (in_store_ok),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  ucd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ucd_back #(
    .DEDUP_DEPTH (DEDUP_DEPTH)
  ) u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .threshold                 (threshold_r),
    .q_empty                   (q_empty),
    .q_cmd                     (pop_cmd),
    .q_pop                     (q_pop),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_status                (out_status),
    .out_total_rises           (out_total_rises),
    .out_rises_since_service   (out_rises_since_service),
    .out_service_count         (out_service_count),
    .out_total_at_last_service (out_total_at_last_service),
    .out_service_due           (out_service_due),
    .out_reset_epoch           (out_reset_epoch)
  );

endmodule

/* rtl/core/ucd_checker.sv */
module ucd_checker
  import ucd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ST_W-1:0]    out_status,
  input logic [CNT_W-1:0]   out_total_rises,
  input logic [CNT_W-1:0]   out_reset_epoch,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_total_rises) && $stable(out_reset_epoch))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_APPLIED || out_status == ST_DUP
      || out_status == ST_ERROR))
    else $error("undefined status code");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // threshold reads back what was last written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_THRESHOLD))
      && (paddr[PADDR_W-1:2] == REG_THRESHOLD) |-> prdata == $past(pwdata))
    else $error("threshold readback mismatch");

endmodule

bind usage_counter_with_command_dedup ucd_checker u_ucd_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import ucd_pkg::*;
();

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] since;
    logic [CNT_W-1:0] services;
    logic [CNT_W-1:0] last_total;
    logic             due;
    logic [CNT_W-1:0] epoch;
  } usage_report_t;

  // Shadow of the lift counters plus the dedup table; queues the report each item yields.
  class usage_tracker;
    logic [CNT_W-1:0]  threshold;
    logic [CNT_W-1:0]  total, since, services, last_total, epoch;
    logic              due;
    logic [HASH_W-1:0] seen_hash [DEDUP_DEPTH_DEF];
    action_t           seen_kind [DEDUP_DEPTH_DEF];
    int unsigned       seen_fill;
    usage_report_t     pending_reports[$];
    int unsigned       failures;

    function new();
      threshold  = THRESHOLD_RST;
      total      = '0;
      since      = '0;
      services   = '0;
      last_total = '0;
      epoch      = '0;
      due        = 1'b0;
      seen_fill  = 0;
      failures   = 0;
    endfunction

    function void note_item(action_t act, logic [HASH_W-1:0] hash, logic ok);
      usage_report_t r;
      bit hit;
      r.status = ST_APPLIED;
      hit = 1'b0;
      case (act)
        ACT_RISE: begin
          if (ok) begin
            total++;
            since++;
            if (since >= threshold) due = 1'b1;
          end else begin
            r.status = ST_ERROR;
          end
        end
        ACT_DONE, ACT_RESET: begin
          for (int i = 0; i < seen_fill; i++)
            if (seen_kind[i] == act && seen_hash[i] == hash) hit = 1'b1;
          if (hash == '0) begin
            r.status = ST_ERROR;
          end else if (hit) begin
            r.status = ST_DUP;   // store_ok does not matter for a repeat
          end else if (!ok) begin
            r.status = ST_ERROR;
          end else begin
            if (act == ACT_DONE) begin
              services++;
              last_total = total;
            end else begin
              total      = '0;
              services   = '0;
              last_total = '0;
              epoch++;
            end
            since = '0;
            due   = 1'b0;
            // once the table is full, commands still apply but are forgotten
            if (seen_fill < DEDUP_DEPTH_DEF) begin
              seen_kind[seen_fill] = act;
              seen_hash[seen_fill] = hash;
              seen_fill++;
            end
          end
        end
        default: r.status = ST_ERROR;
      endcase
      r.total      = total;
      r.since      = since;
      r.services   = services;
      r.last_total = last_total;
      r.due        = due;
      r.epoch      = epoch;
      pending_reports.push_back(r);
    endfunction

    function void check_report(usage_report_t got);
      usage_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result item with no item pending");
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d actual %0d", want.status, got.status);
        failures++;
      end
      if (got.total != want.total) begin
        $error("total_rises: expected %0d actual %0d", want.total, got.total);
        failures++;
      end
      if (got.since != want.since) begin
        $error("rises_since_service: expected %0d actual %0d", want.since, got.since);
        failures++;
      end
      if (got.services != want.services) begin
        $error("service_count: expected %0d actual %0d", want.services, got.services);
        failures++;
      end
      if (got.last_total != want.last_total) begin
        $error("total_at_last_service: expected %0d actual %0d",
               want.last_total, got.last_total);
        failures++;
      end
      if (got.due != want.due) begin
        $error("service_due: expected %0d actual %0d", want.due, got.due);
        failures++;
      end
      if (got.epoch != want.epoch) begin
        $error("reset_epoch: expected %0d actual %0d", want.epoch, got.epoch);
        failures++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   in_action = '0;
  logic [HASH_W-1:0]  in_command_hash = '0;
  logic               in_store_ok = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ST_W-1:0]    out_status;
  logic [CNT_W-1:0]   out_total_rises;
  logic [CNT_W-1:0]   out_rises_since_service;
  logic [CNT_W-1:0]   out_service_count;
  logic [CNT_W-1:0]   out_total_at_last_service;
  logic               out_service_due;
  logic [CNT_W-1:0]   out_reset_epoch;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  usage_tracker      tracker = new();
  bit                calm = 1'b0;
  logic [HASH_W-1:0] recent_hashes[$];

  usage_counter_with_command_dedup uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_action                 (in_action),
    .in_command_hash           (in_command_hash),
    .in_store_ok               (in_store_ok),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_status                (out_status),
    .out_total_rises           (out_total_rises),
    .out_rises_since_service   (out_rises_since_service),
    .out_service_count         (out_service_count),
    .out_total_at_last_service (out_total_at_last_service),
    .out_service_due           (out_service_due),
    .out_reset_epoch           (out_reset_epoch),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .prdata                    (prdata),
    .pready                    (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    usage_report_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status     = status_t'(out_status);
      got.total      = out_total_rises;
      got.since      = out_rises_since_service;
      got.services   = out_service_count;
      got.last_total = out_total_at_last_service;
      got.due        = out_service_due;
      got.epoch      = out_reset_epoch;
      tracker.check_report(got);
    end
  end

  task automatic push_item(action_t act, logic [HASH_W-1:0] hash, logic ok);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_command_hash <= hash;
    in_store_ok     <= ok;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(act, hash, ok);
  endtask

  // drop valid and hold off until every pending result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CNT_W-1:0] value);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.threshold = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // fill: bias toward fresh, storable commands so the dedup table gets full
  task automatic random_item(bit fill);
    action_t           act;
    logic [HASH_W-1:0] hash;
    logic              ok;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (fill && pick < 88) begin
      act  = ($urandom_range(0, 1) != 0) ? ACT_DONE : ACT_RESET;
      hash = $urandom;
      if (hash == '0) hash = 32'd1;
      ok   = 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      act = ACT_RISE;
      else if (pick < 65) act = ACT_DONE;
      else if (pick < 92) act = ACT_RESET;
      else                act = ACT_BAD;
      pick = $urandom_range(0, 99);
      if (pick < 6)
        hash = '0;
      else if (pick < 32 && recent_hashes.size() > 0)
        hash = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
      else if (pick < 36)
        hash = '1;
      else
        hash = $urandom;
      ok = ($urandom_range(0, 99) >= 10);
    end
    if (hash != '0) begin
      recent_hashes.push_back(hash);
      if (recent_hashes.size() > 16) recent_hashes.pop_front();
    end
    push_item(act, hash, ok);
  endtask

  initial begin
    logic [CNT_W-1:0] phase_threshold [6];
    phase_threshold[0] = 32'd3;
    phase_threshold[1] = $urandom_range(2, 16);
    phase_threshold[2] = 32'd1;
    phase_threshold[3] = 32'hFFFF_FFFF;
    phase_threshold[4] = $urandom_range(5, 40);
    phase_threshold[5] = 32'd1000;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: rise/done/reset edge cases, first at the default threshold, then at 1, 0 and all-ones
    push_item(ACT_RISE,  32'hFFFF_FFFF, 1'b1);   // hash ignored on a rise
    push_item(ACT_RISE,  32'h0,         1'b0);   // store failure
    push_item(ACT_DONE,  32'h0,         1'b1);   // missing hash
    push_item(ACT_RESET, 32'h0,         1'b1);
    push_item(ACT_DONE,  32'hFFFF_FFFF, 1'b1);
    push_item(ACT_DONE,  32'hFFFF_FFFF, 1'b0);   // repeat wins over store failure
    push_item(ACT_RESET, 32'hFFFF_FFFF, 1'b0);   // other kind, so not a repeat
    push_item(ACT_RESET, 32'hFFFF_FFFF, 1'b1);
    push_item(ACT_BAD,   32'h1234_5678, 1'b1);
    push_item(ACT_BAD,   32'h0,         1'b0);
    push_item(ACT_RISE,  32'h0,         1'b1);
    push_item(ACT_DONE,  32'h0000_0001, 1'b1);
    push_item(ACT_RISE,  32'h0,         1'b1);
    push_item(ACT_RESET, 32'h8000_0000, 1'b1);
    write_threshold(32'd1);
    push_item(ACT_RISE,  32'h0,         1'b1);
    push_item(ACT_DONE,  32'h0000_0002, 1'b1);
    push_item(ACT_RISE,  32'h0,         1'b0);
    push_item(ACT_RISE,  32'h0,         1'b1);
    write_threshold(32'd0);
    push_item(ACT_RISE,  32'h0,         1'b1);
    push_item(ACT_DONE,  32'h0000_0003, 1'b1);
    push_item(ACT_RISE,  32'h0,         1'b1);
    write_threshold(32'hFFFF_FFFF);
    push_item(ACT_RISE,  32'h0,         1'b1);
    push_item(ACT_RISE,  32'h0,         1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      write_threshold(phase_threshold[phase]);
      calm = (phase == 2);
      for (int n = 0; n < 88; n++) begin
        if (phase == 0 && n == 40) settle();
        random_item(phase >= 1 && tracker.seen_fill < DEDUP_DEPTH_DEF);
      end
    end
    calm = 1'b0;

    settle();
    repeat (300) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_reports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ucd_pkg.sv
rtl/core/ucd_ram.sv
rtl/core/ucd_front.sv
rtl/core/ucd_fifo.sv
rtl/core/ucd_back.sv
rtl/core/usage_counter_with_command_dedup.sv
rtl/core/ucd_checker.sv
sim/testbench.sv
